>>> design/kmer_snp_neighbor_generator_assert.svh
// Assertion macros for the k-mer neighbor generator.
`ifndef KMER_SNP_NEIGHBOR_GENERATOR_ASSERT_SVH
`define KMER_SNP_NEIGHBOR_GENERATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define KSPN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define KSPN_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/kspn_pkg.sv
// Shared types, constants and helper functions of the k-mer neighbor generator.
package kspn_pkg;

  localparam int MAX_BASES = 32;
  localparam int BASE_W    = 2;
  localparam int KMER_W    = MAX_BASES * BASE_W;
  localparam int POS_W     = $clog2(MAX_BASES);
  localparam int LEN_W     = $clog2(MAX_BASES) + 1;
  localparam int SHIFT_W   = $clog2(KMER_W);

  typedef logic [KMER_W-1:0] kmer_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BASE_W-1:0] code_t;

  // Substitution codes, applied one after the other at each position.
  localparam code_t CODE_ONE   = 2'd1;
  localparam code_t CODE_TWO   = 2'd2;
  localparam code_t CODE_THREE = 2'd3;

  // Operand selection for the shared substitute-and-compare unit.
  typedef struct packed {
    pos_t  pos;
    len_t  len;
    code_t code;
  } cmp_req_t;

  // Effective length: zero counts as one base, larger values saturate.
  function automatic len_t eff_len(input len_t raw);
    len_t n;
    n = raw;
    if (raw == '0) begin
      n = len_t'(1);
    end else if (raw > len_t'(MAX_BASES)) begin
      n = len_t'(MAX_BASES);
    end
    return n;
  endfunction

  // Mask that keeps the low 2*n bits of a k-mer.
  function automatic kmer_t len_mask(input len_t n);
    kmer_t m;
    if (n >= len_t'(MAX_BASES)) begin
      m = '1;
    end else begin
      m = (kmer_t'(1) << {n[POS_W-1:0], 1'b0}) - kmer_t'(1);
    end
    return m;
  endfunction

endpackage

>>> design/kspn_revcomp.sv
// Reverse complement of a masked k-mer of variable length.
module kspn_revcomp (
  input  kspn_pkg::kmer_t kmer,
  input  kspn_pkg::len_t  len,
  output kspn_pkg::kmer_t revcomp
);
  import kspn_pkg::*;

  kmer_t                comp;
  kmer_t                flipped;
  logic [SHIFT_W:0]     shamt_full;
  logic [SHIFT_W-1:0]   shamt;

  // Complement the valid bases; slots above the length stay zero.
  assign comp = kmer ^ len_mask(len);

  // Mirror all base slots of the word.
  always_comb begin
    for (int j = 0; j < MAX_BASES; j++) begin
      flipped[BASE_W*(MAX_BASES-1-j) +: BASE_W] = comp[BASE_W*j +: BASE_W];
    end
  end

  // Slide the mirrored bases down so that the last base lands at position 0.
  assign shamt_full = (SHIFT_W+1)'(KMER_W) - {len, 1'b0};
  assign shamt      = shamt_full[SHIFT_W-1:0];
  assign revcomp    = flipped >> shamt;

endmodule

>>> design/kspn_cmp_unit.sv
// Shared unit: substitutes one code into a k-mer and its reverse complement, keeps the smaller.
module kspn_cmp_unit (
  input  kspn_pkg::kmer_t    kmer,
  input  kspn_pkg::kmer_t    revcomp,
  input  kspn_pkg::cmp_req_t req,
  output kspn_pkg::kmer_t    canon
);
  import kspn_pkg::*;

  pos_t  mirror_pos;
  kmer_t fwd_sub;
  kmer_t rev_sub;

  // The base at position i sits at position len-1-i of the reverse complement.
  assign mirror_pos = POS_W'(req.len - len_t'(1) - len_t'(req.pos));

  assign fwd_sub = kmer    ^ (kmer_t'(req.code) << {req.pos, 1'b0});
  assign rev_sub = revcomp ^ (kmer_t'(req.code) << {mirror_pos, 1'b0});

  // Canonical form is the numerically smaller strand.
  assign canon = (fwd_sub < rev_sub) ? fwd_sub : rev_sub;

endmodule

>>> design/kmer_snp_neighbor_generator.sv
// Top level of the k-mer neighbor generator. One k-mer item is taken while the block is idle;
// the next cycle registers its reverse complement and the number of positions to visit (all K
// positions, or the first (K+1)/2 when the k-mer is its own reverse complement). For each
// position one shared substitute-and-compare unit runs three times, once per substitution
// code, and the result item is then held on the output until it is taken. The length register
// is sampled when an item is taken; the user must write it only while the block is idle, as
// the block itself does not enforce this.
`include "kmer_snp_neighbor_generator_assert.svh"

module kmer_snp_neighbor_generator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  kspn_pkg::len_t        cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kspn_pkg::kmer_t       in_kmer_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kspn_pkg::kmer_t       out_source_kmer,
  output kspn_pkg::pos_t        out_base_position,
  output kspn_pkg::kmer_t       out_neighbor_one,
  output kspn_pkg::kmer_t       out_neighbor_two,
  output kspn_pkg::kmer_t       out_neighbor_three,
  output logic                  out_final_flag
);
  import kspn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REV,
    S_CALC,
    S_EMIT
  } state_t;

  state_t   state_r;
  len_t     kmer_length_r;
  len_t     len_r;
  len_t     pos_limit_r;
  pos_t     pos_r;
  code_t    code_r;
  kmer_t    kmer_r;
  kmer_t    revcomp_r;
  kmer_t    nb_one_r;
  kmer_t    nb_two_r;
  kmer_t    nb_three_r;
  kmer_t    revcomp_nxt;
  kmer_t    canon;
  cmp_req_t req;
  logic     last_pos;

  // Length register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= len_t'(MAX_BASES);
    end else if (cfg_wr_en) begin
      kmer_length_r <= cfg_wr_data;
    end
  end

  kspn_revcomp u_revcomp (
    .kmer    (kmer_r),
    .len     (len_r),
    .revcomp (revcomp_nxt)
  );

  assign req.pos  = pos_r;
  assign req.len  = len_r;
  assign req.code = code_r;

  kspn_cmp_unit u_cmp (
    .kmer    (kmer_r),
    .revcomp (revcomp_r),
    .req     (req),
    .canon   (canon)
  );

  assign last_pos = ({1'b0, pos_r} + len_t'(1)) == pos_limit_r;

  // Sequencer: load, reverse complement, then for each position three compare passes and a result item to hand out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      code_r      <= CODE_ONE;
      pos_limit_r <= '0;
      len_r       <= '0;
      kmer_r      <= '0;
      revcomp_r   <= '0;
      nb_one_r    <= '0;
      nb_two_r    <= '0;
      nb_three_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            len_r   <= eff_len(kmer_length_r);
            kmer_r  <= in_kmer_bits & len_mask(eff_len(kmer_length_r));
            state_r <= S_REV;
          end
        end
        S_REV: begin
          revcomp_r   <= revcomp_nxt;
          pos_limit_r <= (revcomp_nxt == kmer_r) ? ((len_r + len_t'(1)) >> 1) : len_r;
          pos_r       <= '0;
          code_r      <= CODE_ONE;
          state_r     <= S_CALC;
        end
        S_CALC: begin
          unique case (code_r)
            CODE_ONE: begin
              nb_one_r <= canon;
              code_r   <= CODE_TWO;
            end
            CODE_TWO: begin
              nb_two_r <= canon;
              code_r   <= CODE_THREE;
            end
            default: begin
              nb_three_r <= canon;
              code_r     <= CODE_ONE;
              state_r    <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (last_pos) begin
              state_r <= S_IDLE;
            end else begin
              pos_r   <= pos_r + pos_t'(1);
              state_r <= S_CALC;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result item straight from the registers.
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_EMIT);
  assign out_source_kmer    = kmer_r;
  assign out_base_position  = pos_r;
  assign out_neighbor_one   = nb_one_r;
  assign out_neighbor_two   = nb_two_r;
  assign out_neighbor_three = nb_three_r;
  assign out_final_flag     = last_pos;

  // No new item is taken while a result is pending.
  `KSPN_ASSERT_ALL(a_no_accept_while_emit, out_valid |-> in_stall, "input open during output")
  // A result never names a position beyond the visit limit.
  `KSPN_ASSERT_RST(a_pos_in_limit, out_valid |-> ({1'b0, out_base_position} < pos_limit_r), "position out of range")
  // A taken non-final result is followed by compute cycles for the next position.
  `KSPN_ASSERT_RST(a_next_pos, (out_valid && !out_stall && !out_final_flag) |=> (!out_valid && (out_base_position == $past(out_base_position) + 5'd1)), "position did not advance")
  // An accepted item starts with the reverse-complement cycle.
  `KSPN_ASSERT_RST(a_accept_to_rev, (in_valid && !in_stall) |=> (state_r == S_REV), "accept did not start work")

endmodule
